// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, masked while reset is held.
`define BSIM_ASSERT(lbl, pr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pr) else $error(msg);
// Clocked assertion that also holds across reset.
`define BSIM_ASSERT_RST(lbl, pr, msg) \
  lbl: assert property (@(posedge clk) pr) else $error(msg);
`endif

// ===== sv/bsim_pkg.sv =====
// Shared constants and types for the broadcast source index map.
package bsim_pkg;
  localparam int DATA_W          = 32;
  localparam int SIZE_W          = 16;
  localparam int STRIDE_W        = 32;
  localparam int PROD_W          = SIZE_W + STRIDE_W;
  localparam int DIV_STEPS       = DATA_W;
  localparam int NUM_DIMS_REG    = 4;
  localparam int CFG_IDX_W       = 4;
  localparam int MAX_DIMS_DEF    = 4;
  localparam int INDEX_WIDTH_DEF = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_DIM0   = 4'd0,
    REG_SIZE_DIM1   = 4'd1,
    REG_SIZE_DIM2   = 4'd2,
    REG_SIZE_DIM3   = 4'd3,
    REG_STRIDE_DIM0 = 4'd4,
    REG_STRIDE_DIM1 = 4'd5,
    REG_STRIDE_DIM2 = 4'd6,
    REG_STRIDE_DIM3 = 4'd7
  } cfg_reg_t;
endpackage

// ===== sv/bsim_div_cell.sv =====
// One restoring-division step cell: produces one quotient bit per stage.
module bsim_div_cell #(
  parameter int ACC_W = bsim_pkg::INDEX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [bsim_pkg::SIZE_W-1:0]   divisor,
  input  logic                          v_in,
  input  logic [bsim_pkg::DATA_W-1:0]   w_in,
  input  logic [bsim_pkg::SIZE_W-1:0]   r_in,
  input  logic [ACC_W-1:0]              acc_in,
  output logic                          v_out,
  output logic [bsim_pkg::DATA_W-1:0]   w_out,
  output logic [bsim_pkg::SIZE_W-1:0]   r_out,
  output logic [ACC_W-1:0]              acc_out
);
  logic                          v_r;
  logic [bsim_pkg::DATA_W-1:0]   w_r, w_nxt;
  logic [bsim_pkg::SIZE_W-1:0]   r_r, r_nxt;
  logic [ACC_W-1:0]              acc_r;
  logic [bsim_pkg::SIZE_W:0]     trial;
  logic [bsim_pkg::SIZE_W:0]     diff;
  logic                          ge;

  // shift next dividend bit into the partial remainder, subtract if it fits
  always_comb begin
    trial = {r_in, w_in[bsim_pkg::DATA_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
    r_nxt = ge ? diff[bsim_pkg::SIZE_W-1:0] : trial[bsim_pkg::SIZE_W-1:0];
    w_nxt = {w_in[bsim_pkg::DATA_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r   <= w_nxt;
      r_r   <= r_nxt;
      acc_r <= acc_in;
    end
  end

  assign v_out   = v_r;
  assign w_out   = w_r;
  assign r_out   = r_r;
  assign acc_out = acc_r;
endmodule

// ===== sv/bsim_mac_cell.sv =====
// Coordinate times stride, then accumulate: two registered stages.
module bsim_mac_cell #(
  parameter int ACC_W = bsim_pkg::INDEX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [bsim_pkg::STRIDE_W-1:0] stride,
  input  logic                          v_in,
  input  logic [bsim_pkg::DATA_W-1:0]   w_in,
  input  logic [bsim_pkg::SIZE_W-1:0]   r_in,
  input  logic [ACC_W-1:0]              acc_in,
  output logic                          v_out,
  output logic [bsim_pkg::DATA_W-1:0]   w_out,
  output logic [bsim_pkg::SIZE_W-1:0]   r_out,
  output logic [ACC_W-1:0]              acc_out
);
  logic                          va_r, vb_r;
  logic [bsim_pkg::DATA_W-1:0]   wa_r, wb_r;
  logic [bsim_pkg::PROD_W-1:0]   prod_r;
  logic [ACC_W-1:0]              acca_r, accb_r, acc_nxt;

  assign acc_nxt = acca_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= v_in;
      vb_r <= va_r;
    end
  end

  // multiply stage, then add stage
  always_ff @(posedge clk) begin
    if (en) begin
      wa_r   <= w_in;
      prod_r <= r_in * stride;
      acca_r <= acc_in;
      wb_r   <= wa_r;
      accb_r <= acc_nxt;
    end
  end

  assign v_out   = vb_r;
  assign w_out   = wb_r;
  assign r_out   = '0;
  assign acc_out = accb_r;
endmodule

// ===== sv/broadcast_source_index_map_unit.sv =====
// Throughput: one transaction per cycle unless the output stalls; each dimension
// is a chain of 32 divide cells (one quotient bit each) followed by a multiply and
// an add stage, and the dimensions run in series before the output register.
// Stalls come only from the output register; the chain moves if its end is empty.
// Reset (rst_n, synchronous): sizes 1, strides 0, all pipeline valids cleared.
module broadcast_source_index_map_unit #(
  parameter int MAX_DIMS    = bsim_pkg::MAX_DIMS_DEF,
  parameter int INDEX_WIDTH = bsim_pkg::INDEX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bsim_pkg::DATA_W-1:0]    in_tdata,   // [31:0] out_index
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bsim_pkg::DATA_W-1:0]    out_tdata,  // [31:0] src_index
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsim_pkg::STRIDE_W-1:0]  cfg_data
);
  localparam int SPD = bsim_pkg::DIV_STEPS + 1;
  localparam int NS  = MAX_DIMS * SPD;

  logic [bsim_pkg::SIZE_W-1:0]   size_r   [bsim_pkg::NUM_DIMS_REG];
  logic [bsim_pkg::STRIDE_W-1:0] stride_r [bsim_pkg::NUM_DIMS_REG];
  logic [bsim_pkg::SIZE_W-1:0]   div_eff  [bsim_pkg::NUM_DIMS_REG];

  logic                          v   [0:NS];
  logic [bsim_pkg::DATA_W-1:0]   w   [0:NS];
  logic [bsim_pkg::SIZE_W-1:0]   r   [0:NS];
  logic [INDEX_WIDTH-1:0]        acc [0:NS];

  logic                          en, out_ld;
  logic                          out_valid_r;
  logic [bsim_pkg::DATA_W-1:0]   out_data_r;

  // configuration register file
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bsim_pkg::NUM_DIMS_REG; i++) begin
        size_r[i]   <= bsim_pkg::SIZE_W'(1);
        stride_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        bsim_pkg::REG_SIZE_DIM0:   size_r[0]   <= cfg_data[bsim_pkg::SIZE_W-1:0];
        bsim_pkg::REG_SIZE_DIM1:   size_r[1]   <= cfg_data[bsim_pkg::SIZE_W-1:0];
        bsim_pkg::REG_SIZE_DIM2:   size_r[2]   <= cfg_data[bsim_pkg::SIZE_W-1:0];
        bsim_pkg::REG_SIZE_DIM3:   size_r[3]   <= cfg_data[bsim_pkg::SIZE_W-1:0];
        bsim_pkg::REG_STRIDE_DIM0: stride_r[0] <= cfg_data;
        bsim_pkg::REG_STRIDE_DIM1: stride_r[1] <= cfg_data;
        bsim_pkg::REG_STRIDE_DIM2: stride_r[2] <= cfg_data;
        bsim_pkg::REG_STRIDE_DIM3: stride_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero size behaves as size one
  always_comb begin
    for (int i = 0; i < bsim_pkg::NUM_DIMS_REG; i++) begin
      div_eff[i] = (size_r[i] == '0) ? bsim_pkg::SIZE_W'(1) : size_r[i];
    end
  end

  // chain control: output register loads when free, chain moves unless it is blocked
  assign out_ld    = !out_valid_r || out_tready;
  assign en        = !v[NS] || out_ld;
  assign in_tready = en;

  assign v[0]   = in_tvalid;
  assign w[0]   = in_tdata;
  assign r[0]   = '0;
  assign acc[0] = '0;

  // innermost dimension first
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    localparam int DI = bsim_pkg::NUM_DIMS_REG - 1 - d;
    for (genvar k = 0; k < bsim_pkg::DIV_STEPS; k++) begin : g_step
      localparam int S = d * SPD + k;
      bsim_div_cell #(.ACC_W(INDEX_WIDTH)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .divisor (div_eff[DI]),
        .v_in    (v[S]),
        .w_in    (w[S]),
        .r_in    (r[S]),
        .acc_in  (acc[S]),
        .v_out   (v[S+1]),
        .w_out   (w[S+1]),
        .r_out   (r[S+1]),
        .acc_out (acc[S+1])
      );
    end
    bsim_mac_cell #(.ACC_W(INDEX_WIDTH)) u_mac (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .stride  (stride_r[DI]),
      .v_in    (v[d*SPD + bsim_pkg::DIV_STEPS]),
      .w_in    (w[d*SPD + bsim_pkg::DIV_STEPS]),
      .r_in    (r[d*SPD + bsim_pkg::DIV_STEPS]),
      .acc_in  (acc[d*SPD + bsim_pkg::DIV_STEPS]),
      .v_out   (v[(d+1)*SPD]),
      .w_out   (w[(d+1)*SPD]),
      .r_out   (r[(d+1)*SPD]),
      .acc_out (acc[(d+1)*SPD])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_data_r <= bsim_pkg::DATA_W'(acc[NS]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // final quotient and remainder are not needed
  logic unused_tail;
  assign unused_tail = ^{w[NS], r[NS]};
endmodule

// ===== sv/bsim_checker.sv =====
// Port-level checker for the broadcast source index map, bound to the top level.
`include "assert_macros.svh"
module bsim_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic cfg_ready
);
  `BSIM_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_tvalid, "output valid after reset")
  `BSIM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "output dropped")
  `BSIM_ASSERT(a_stall_cause, !in_tready |-> out_tvalid && !out_tready, "input stalled without output stall")
  `BSIM_ASSERT(a_cfg_ready, cfg_ready, "configuration port not ready")
endmodule

bind broadcast_source_index_map_unit bsim_checker u_bsim_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .cfg_ready  (cfg_ready)
);

// ===== sim/tb_top.sv =====
// Testbench for the broadcast source index map: predicts and checks source indices.
module tb_top;

  // Scoreboard: predicts src_index per accepted out_index and checks results
  class src_index_board;
    bit [15:0] dim_size[4];
    bit [31:0] dim_stride[4];
    bit [31:0] pending_src[$];
    int mismatches;

    function void set_reg(bsim_pkg::cfg_reg_t idx, bit [31:0] val);
      if (idx <= bsim_pkg::REG_SIZE_DIM3) dim_size[idx] = val[15:0];
      else dim_stride[idx - bsim_pkg::REG_STRIDE_DIM0] = val;
    endfunction

    function void note_index(bit [31:0] lin);
      bit [31:0] rem;
      bit [31:0] acc;
      bit [31:0] coord;
      rem = lin;
      acc = '0;
      // innermost dimension first; zero size behaves as size 1
      for (int d = 3; d >= 0; d--) begin
        coord = '0;
        if (dim_size[d] != 0) begin
          coord = rem % dim_size[d];
          rem = rem / dim_size[d];
        end
        acc = acc + coord * dim_stride[d];
      end
      pending_src.push_back(acc);
    endfunction

    function void check_src(bit [31:0] got);
      bit [31:0] exp_src;
      if (pending_src.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result src_index=%h", got);
        return;
      end
      exp_src = pending_src.pop_front();
      if (exp_src !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("src_index mismatch: expected %h actual %h", exp_src, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [31:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [bsim_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  src_index_board sb;

  localparam int PIPE_LAT = 4 * (bsim_pkg::DIV_STEPS + 2) + 1;

  broadcast_source_index_map_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // mostly short gaps, a few long, with stall-free stretches
  function automatic int gap_len(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random backpressure, check each accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_src(out_tdata);
    out_tready <= (gap_len(($urandom_range(0, 3) == 0) ? 0 : 1) == 0);
  end

  // valid stays high after a write so back-to-back writes need no second assignment
  task automatic write_reg(bsim_pkg::cfg_reg_t idx, bit [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // a write past the register list must be ignored
  task automatic write_bad_index(bit [3:0] idx);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= $urandom;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic cfg_idle();
    cfg_valid <= 0;
  endtask

  // valid drops only before a gap or when the burst is drained
  task automatic send_index(bit [31:0] lin, int mode);
    int g;
    g = gap_len(mode);
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= lin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_index(lin);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending_src.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_shape(bit [15:0] s0, s1, s2, s3, bit [31:0] t0, t1, t2, t3);
    write_reg(bsim_pkg::REG_SIZE_DIM0, s0);
    write_reg(bsim_pkg::REG_SIZE_DIM1, s1);
    write_reg(bsim_pkg::REG_SIZE_DIM2, s2);
    write_reg(bsim_pkg::REG_SIZE_DIM3, s3);
    write_reg(bsim_pkg::REG_STRIDE_DIM0, t0);
    write_reg(bsim_pkg::REG_STRIDE_DIM1, t1);
    write_reg(bsim_pkg::REG_STRIDE_DIM2, t2);
    write_reg(bsim_pkg::REG_STRIDE_DIM3, t3);
  endtask

  // random index, mostly inside the tensor, sometimes anywhere
  function automatic bit [31:0] pick_index();
    longint unsigned total;
    total = 1;
    for (int d = 0; d < 4; d++) total *= (sb.dim_size[d] == 0) ? 1 : sb.dim_size[d];
    if ($urandom_range(0, 3) == 0 || total > 64'hFFFF_FFFF) return $urandom;
    return $urandom_range(0, int'(total - 1));
  endfunction

  function automatic bit [15:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r < 4) return 16'd1;
    if (r < 8) return 16'($urandom_range(2, 12));
    return 16'($urandom);
  endfunction

  function automatic bit [31:0] pick_stride();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 4) return $urandom_range(1, 1000);
    return $urandom;
  endfunction

  initial begin
    sb = new();
    for (int d = 0; d < 4; d++) begin
      sb.dim_size[d] = 1;
      sb.dim_stride[d] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset shape gives zero for any index
    send_index(32'd0, 0);
    send_index(32'hFFFF_FFFF, 0);
    drain();
    // broadcast along dim 2 of a 2x3x4x5 tensor
    load_shape(2, 3, 4, 5, 15, 5, 0, 1);
    cfg_idle();
    send_index(32'd0, 0);
    send_index(32'd119, 0);
    send_index(32'd120, 0);        // index beyond tensor wraps
    send_index(32'd67, 0);
    drain();
    // zero sizes act as 1; bad register writes ignored
    load_shape(0, 7, 0, 9, 32'hFFFF_FFFF, 3, 32'h8000_0000, 32'hFFFF_FFFF);
    write_bad_index(4'd8);
    write_bad_index(4'd15);
    cfg_idle();
    send_index(32'd62, 0);
    send_index(32'hFFFF_FFFF, 0);
    send_index(32'h8000_0000, 0);
    drain();
    // maximum sizes and strides
    load_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    cfg_idle();
    send_index(32'hFFFF_FFFF, 0);
    send_index(32'hFFFE_FFFF, 0);
    send_index(32'h5555_AAAA, 0);
    send_index(32'h0000_FFFF, 0);
    drain();

    // random phases, each with a fresh shape
    for (int ph = 0; ph < 18; ph++) begin
      load_shape(pick_size(), pick_size(), pick_size(), pick_size(),
                 pick_stride(), pick_stride(), pick_stride(), pick_stride());
      if ($urandom_range(0, 3) == 0) write_bad_index(4'($urandom_range(8, 15)));
      cfg_idle();
      for (int i = 0; i < 30; i++) send_index(pick_index(), ph % 3);
      drain();
    end

    repeat (PIPE_LAT + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_src.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
